// ----- hdl/pixel_hit_cut_accumulator_defines.svh -----
// Assertion macros for the pixel hit cut accumulator.
`ifndef PIXEL_HIT_CUT_ACCUMULATOR_DEFINES_SVH
`define PIXEL_HIT_CUT_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PHCA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define PHCA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/phca_pkg.sv -----
// Shared types and constants for the pixel hit cut accumulator.
package phca_pkg;
   localparam int CAL_W      = 42;
   localparam int LINK_W     = 37;
   localparam int CNT_W      = 32;
   localparam int CALM_W     = 14;
   localparam int LINKM_W    = 9;
   localparam int Q_W        = 14;
   localparam int DIV_STEPS  = 14;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CNT_W-1:0] CNT_SAT = '1;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type REG_AMP_MIN   = 3'd0;
   localparam csr_idx_type REG_AMP_MAX   = 3'd1;
   localparam csr_idx_type REG_CAL_MIN   = 3'd2;
   localparam csr_idx_type REG_CAL_MAX   = 3'd3;
   localparam csr_idx_type REG_RATIO_MIN = 3'd4;
   localparam csr_idx_type REG_RATIO_MAX = 3'd5;

   localparam logic signed [15:0] AMP_MIN_RST   = 16'sd6400;
   localparam logic signed [15:0] AMP_MAX_RST   = 16'sd19200;
   localparam logic [9:0]         CAL_MIN_RST   = 10'd170;
   localparam logic [9:0]         CAL_MAX_RST   = 10'd190;
   localparam logic [5:0]         RATIO_MIN_RST = 6'd2;
   localparam logic [5:0]         RATIO_MAX_RST = 6'd10;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic req_ready;
      logic fetch;
      logic update;
      logic div_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic req_fire;
      logic oob;
      logic need_div;
      logic div_last;
      logic out_free;
   } sts_type;
endpackage

// ----- hdl/phca_if.sv -----
// Channel interfaces: request, response and register write.
interface phca_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [3:0]         pixel_row;
   logic [3:0]         pixel_col;
   logic [9:0]         cal_value;
   logic [8:0]         tot_value;
   logic [4:0]         link_id;
   logic signed [15:0] amp_ch2;

   modport source(output valid, opcode, pixel_row, pixel_col, cal_value, tot_value,
                  link_id, amp_ch2, input ready);
   modport sink(input valid, opcode, pixel_row, pixel_col, cal_value, tot_value,
                link_id, amp_ch2, output ready);
endinterface

interface phca_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [41:0] cal_total;
   logic [36:0] link_total;
   logic [31:0] hit_total;
   logic [13:0] cal_mean;
   logic [8:0]  link_mean;

   modport source(output valid, accepted, cal_total, link_total, hit_total, cal_mean,
                  link_mean, input ready);
   modport sink(input valid, accepted, cal_total, link_total, hit_total, cal_mean,
                link_mean, output ready);
endinterface

interface phca_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/pixel_hit_cut_accumulator.sv -----
// Pixel hit cut accumulator: per-pixel hit sums behind amplitude, calibration and ratio cuts.
//
// Usage:
// - req_ch carries one request: opcode 0 applies the cuts to a hit and adds it to its
//   pixel, opcode 1 reads one pixel. Every request yields exactly one response on rsp_ch.
// - csr_ch writes the six cut registers; it is always ready. Write it only while idle.
// - One request is in work at a time. After acceptance the store is read, the pixel is
//   updated, then a radix-2 divider forms both averages, one quotient bit per cycle, and
//   the response register loads; a pixel with zero count skips the divider and a pixel
//   outside the map goes straight to the response register. The next request can be
//   taken in the cycle after the response register loads. The divider sets the hit rate.
// - Reset restores the register defaults and sweeps the store to zero, one entry per
//   cycle, over all MAP_ROWS*MAP_COLS entries, with req_ch not ready during the sweep.
// - If rsp_ch stalls, the last response waits in the response register; the next request is
//   still taken, its result then waits and req_ch stays not ready until it can be loaded.
module pixel_hit_cut_accumulator #(
   parameter int MAP_ROWS = 16,
   parameter int MAP_COLS = 16
) (
   input logic         clock,
   input logic         reset,
   phca_req_if.sink    req_ch,
   phca_rsp_if.source  rsp_ch,
   phca_csr_if.sink    csr_ch
);
   import phca_pkg::*;
   `include "pixel_hit_cut_accumulator_defines.svh"

   cmd_type   cmd;
   sts_type   sts;
   state_type state_w;

   phca_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd),
      .state (state_w)
   );

   phca_dp #(
      .MAP_ROWS (MAP_ROWS),
      .MAP_COLS (MAP_COLS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   `PHCA_ASSERT_NEXT(a_busy_after_req, req_ch.valid && req_ch.ready, !req_ch.ready, "request taken while busy")
   `PHCA_ASSERT_NOW(a_no_req_in_clear, state_w == ST_CLEAR, !req_ch.ready, "request ready during clear")
   `PHCA_ASSERT_NEXT(a_emit_loads_rsp, state_w == ST_EMIT && (!rsp_ch.valid || rsp_ch.ready), rsp_ch.valid, "response not loaded")
endmodule

// ----- hdl/phca_dp.sv -----
// Datapath: registers, pixel store, cut logic, divider and response register.
module phca_dp #(
   parameter int MAP_ROWS = 16,
   parameter int MAP_COLS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  phca_pkg::cmd_type cmd,
   output phca_pkg::sts_type sts,
   phca_req_if.sink         req,
   phca_rsp_if.source       rsp,
   phca_csr_if.sink         csr
);
   import phca_pkg::*;

   localparam int DEPTH  = MAP_ROWS * MAP_COLS;
   localparam int AW     = $clog2(DEPTH);
   localparam int WORD_W = CAL_W + LINK_W + CNT_W;

   logic [WORD_W-1:0] mem [DEPTH];

   logic signed [15:0] amp_min_ff, amp_max_ff;
   logic [9:0]         cal_min_ff, cal_max_ff;
   logic [5:0]         ratio_min_ff, ratio_max_ff;

   logic [AW-1:0]      clr_ff;
   logic [AW-1:0]      idx_ff;
   logic               op_ff, oob_ff, cut_ff, acc_ff;
   logic [9:0]         cal_ff;
   logic [8:0]         tot_ff;
   logic [4:0]         link_ff;
   logic signed [15:0] amp_ff;
   logic [WORD_W-1:0]  rd_ff;
   logic [CAL_W-1:0]   cs_ff;
   logic [LINK_W-1:0]  ls_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [CNT_W-1:0]   crem_ff, lrem_ff;
   logic [Q_W-1:0]     csh_ff, lsh_ff;
   logic [3:0]         div_cnt_ff;
   logic               rsp_valid_ff;

   logic               req_fire, oob;
   logic [31:0]        idx_full;
   logic               amp_ok, cal_ok, ratio_ok;
   logic [9:0]         tot_adj;
   logic [14:0]        num;
   logic [12:0]        c8;
   logic [18:0]        lo_bound, hi_bound;
   logic [CAL_W-1:0]   cs_rd, cs_new;
   logic [LINK_W-1:0]  ls_rd, ls_new;
   logic [CNT_W-1:0]   n_rd, n_new;
   logic               hit;
   logic [CNT_W:0]     ct, lt;
   logic               cge, lge;

   assign csr.ready = 1'b1;
   assign req.ready = cmd.req_ready;
   assign req_fire  = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_min_ff   <= AMP_MIN_RST;
         amp_max_ff   <= AMP_MAX_RST;
         cal_min_ff   <= CAL_MIN_RST;
         cal_max_ff   <= CAL_MAX_RST;
         ratio_min_ff <= RATIO_MIN_RST;
         ratio_max_ff <= RATIO_MAX_RST;
      end else if (csr.valid) begin
         case (csr.index)
            REG_AMP_MIN:   amp_min_ff   <= csr.data;
            REG_AMP_MAX:   amp_max_ff   <= csr.data;
            REG_CAL_MIN:   cal_min_ff   <= csr.data[9:0];
            REG_CAL_MAX:   cal_max_ff   <= csr.data[9:0];
            REG_RATIO_MIN: ratio_min_ff <= csr.data[5:0];
            REG_RATIO_MAX: ratio_max_ff <= csr.data[5:0];
            default: ;
         endcase
      end
   end

   assign oob = ({5'b0, req.pixel_row} >= 9'(MAP_ROWS)) ||
                ({5'b0, req.pixel_col} >= 9'(MAP_COLS));
   assign idx_full = 32'(req.pixel_row) * 32'(MAP_COLS) + 32'(req.pixel_col);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req.opcode;
         oob_ff  <= oob;
         idx_ff  <= idx_full[AW-1:0];
         cal_ff  <= req.cal_value;
         tot_ff  <= req.tot_value;
         link_ff <= req.link_id;
         amp_ff  <= req.amp_ch2;
      end
   end

   // ratio cut by cross-multiplying: rmin*8*cal < 25*(2*tot - tot/32) < rmax*8*cal
   assign amp_ok   = (amp_ff > amp_min_ff) && (amp_ff < amp_max_ff);
   assign cal_ok   = (cal_ff > cal_min_ff) && (cal_ff < cal_max_ff);
   assign tot_adj  = {tot_ff, 1'b0} - 10'(tot_ff[8:5]);
   assign num      = 15'(tot_adj) * 15'd25;
   assign c8       = {cal_ff, 3'b000};
   assign lo_bound = 19'(ratio_min_ff) * 19'(c8);
   assign hi_bound = 19'(ratio_max_ff) * 19'(c8);
   assign ratio_ok = (19'(num) > lo_bound) && (19'(num) < hi_bound);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   assign cs_rd = rd_ff[WORD_W-1 -: CAL_W];
   assign ls_rd = rd_ff[CNT_W +: LINK_W];
   assign n_rd  = rd_ff[CNT_W-1:0];
   assign hit   = !op_ff && (n_rd != CNT_SAT) && cut_ff;
   assign cs_new = hit ? cs_rd + CAL_W'(cal_ff) : cs_rd;
   assign ls_new = hit ? ls_rd + LINK_W'(link_ff) : ls_rd;
   assign n_new  = hit ? n_rd + 1'b1 : n_rd;

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clr_ff] <= '0;
      end else if (cmd.update && hit) begin
         mem[idx_ff] <= {cs_new, ls_new, n_new};
      end
      if (cmd.fetch) begin
         rd_ff  <= mem[idx_ff];
         cut_ff <= amp_ok && cal_ok && ratio_ok;
      end
   end

   // one quotient bit per step; remainder always stays below the count
   assign ct  = {crem_ff, csh_ff[Q_W-1]};
   assign lt  = {lrem_ff, lsh_ff[Q_W-1]};
   assign cge = ct >= {1'b0, n_ff};
   assign lge = lt >= {1'b0, n_ff};

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         acc_ff     <= hit;
         cs_ff      <= cs_new;
         ls_ff      <= ls_new;
         n_ff       <= n_new;
         crem_ff    <= cs_new[CAL_W-1:10];
         csh_ff     <= {cs_new[9:0], 4'b0000};
         lrem_ff    <= {5'b0, ls_new[LINK_W-1:10]};
         lsh_ff     <= {ls_new[9:0], 4'b0000};
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         crem_ff    <= cge ? CNT_W'(ct - {1'b0, n_ff}) : ct[CNT_W-1:0];
         lrem_ff    <= lge ? CNT_W'(lt - {1'b0, n_ff}) : lt[CNT_W-1:0];
         csh_ff     <= {csh_ff[Q_W-2:0], cge};
         lsh_ff     <= {lsh_ff[Q_W-2:0], lge};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (oob_ff) begin
            rsp.accepted   <= 1'b0;
            rsp.cal_total  <= '0;
            rsp.link_total <= '0;
            rsp.hit_total  <= '0;
            rsp.cal_mean   <= '0;
            rsp.link_mean  <= '0;
         end else begin
            rsp.accepted   <= acc_ff;
            rsp.cal_total  <= cs_ff;
            rsp.link_total <= ls_ff;
            rsp.hit_total  <= n_ff;
            rsp.cal_mean   <= (n_ff == '0) ? '0 : csh_ff[CALM_W-1:0];
            rsp.link_mean  <= (n_ff == '0) ? '0 : lsh_ff[LINKM_W-1:0];
         end
      end
   end

   assign rsp.valid = rsp_valid_ff;

   assign sts.clr_last = (clr_ff == AW'(DEPTH - 1));
   assign sts.req_fire = req_fire;
   assign sts.oob      = oob;
   assign sts.need_div = (n_new != '0);
   assign sts.div_last = (div_cnt_ff == 4'(DIV_STEPS - 1));
   assign sts.out_free = !rsp_valid_ff || rsp.ready;
endmodule

// ----- hdl/phca_ctrl.sv -----
// Controller: sequences the store clear after reset, then fetch, update, divide and emit for each request.
module phca_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  phca_pkg::sts_type   sts,
   output phca_pkg::cmd_type   cmd,
   output phca_pkg::state_type state
);
   import phca_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (sts.clr_last) state_in = ST_IDLE;
         ST_IDLE:   if (sts.req_fire) state_in = sts.oob ? ST_EMIT : ST_FETCH;
         ST_FETCH:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = sts.need_div ? ST_DIVIDE : ST_EMIT;
         ST_DIVIDE: if (sts.div_last) state_in = ST_EMIT;
         ST_EMIT:   if (sts.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_CLEAR:  cmd.clear     = 1'b1;
         ST_IDLE:   cmd.req_ready = 1'b1;
         ST_FETCH:  cmd.fetch     = 1'b1;
         ST_UPDATE: cmd.update    = 1'b1;
         ST_DIVIDE: cmd.div_step  = 1'b1;
         ST_EMIT:   cmd.emit      = sts.out_free;
         default:   cmd = '0;
      endcase
   end

   assign state = state_ff;
endmodule

// ----- tb/sv/phca_checker.sv -----
// Response checker: predicts every pixel request and compares each response against it.
module phca_checker (
   input logic        clock,
   input logic        reset,
   phca_req_if.sink   req_mon,
   phca_rsp_if.sink   rsp_mon,
   phca_csr_if.sink   csr_mon,
   output int         fail_count,
   output int         pending_count
);
   import phca_pkg::*;

   typedef struct {
      logic              accepted;
      logic [CAL_W-1:0]  cal_total;
      logic [LINK_W-1:0] link_total;
      logic [CNT_W-1:0]  hit_total;
      logic [CALM_W-1:0] cal_mean;
      logic [LINKM_W-1:0] link_mean;
   } pixel_result_type;

   pixel_result_type expected_responses[$];

   logic signed [15:0] amp_lo, amp_hi;
   logic [9:0]         cal_lo, cal_hi;
   logic [5:0]         ratio_lo, ratio_hi;
   logic [CAL_W-1:0]   cal_sums[256];
   logic [LINK_W-1:0]  link_sums[256];
   logic [CNT_W-1:0]   hit_counts[256];

   assign pending_count = expected_responses.size();

   function automatic logic hit_passes(logic signed [15:0] amp, logic [9:0] cal,
                                       logic [8:0] tot);
      logic [63:0] scaled_tot;
      logic [63:0] cal8;
      scaled_tot = 64'd25 * (64'(tot) * 2 - 64'(tot >> 5));
      cal8 = 64'd8 * 64'(cal);
      if (!(amp > amp_lo && amp < amp_hi)) return 1'b0;
      if (!(cal > cal_lo && cal < cal_hi)) return 1'b0;
      return scaled_tot > 64'(ratio_lo) * cal8 && scaled_tot < 64'(ratio_hi) * cal8;
   endfunction

   function automatic pixel_result_type apply_request();
      pixel_result_type r;
      int idx;
      logic [63:0] cs, ls, n;
      idx = {req_mon.pixel_row, req_mon.pixel_col};
      r.accepted = 1'b0;
      if (req_mon.opcode == 1'b0 && hit_counts[idx] != CNT_SAT &&
          hit_passes(req_mon.amp_ch2, req_mon.cal_value, req_mon.tot_value)) begin
         cal_sums[idx] += CAL_W'(req_mon.cal_value);
         link_sums[idx] += LINK_W'(req_mon.link_id);
         hit_counts[idx] += 1;
         r.accepted = 1'b1;
      end
      cs = 64'(cal_sums[idx]);
      ls = 64'(link_sums[idx]);
      n = 64'(hit_counts[idx]);
      r.cal_total = cal_sums[idx];
      r.link_total = link_sums[idx];
      r.hit_total = hit_counts[idx];
      r.cal_mean = (n == 0) ? '0 : CALM_W'((cs << 4) / n);
      r.link_mean = (n == 0) ? '0 : LINKM_W'((ls << 4) / n);
      return r;
   endfunction

   always @(posedge clock) begin
      pixel_result_type exp_r;
      if (reset) begin
         amp_lo = AMP_MIN_RST;   amp_hi = AMP_MAX_RST;
         cal_lo = CAL_MIN_RST;   cal_hi = CAL_MAX_RST;
         ratio_lo = RATIO_MIN_RST; ratio_hi = RATIO_MAX_RST;
         for (int i = 0; i < 256; i++) begin
            cal_sums[i] = '0; link_sums[i] = '0; hit_counts[i] = '0;
         end
         expected_responses.delete();
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_responses.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               exp_r = expected_responses.pop_front();
               if (rsp_mon.accepted !== exp_r.accepted) begin
                  $error("accepted: expected %0d got %0d", exp_r.accepted, rsp_mon.accepted);
                  fail_count++;
               end
               if (rsp_mon.cal_total !== exp_r.cal_total) begin
                  $error("cal_total: expected %0d got %0d", exp_r.cal_total,
                         rsp_mon.cal_total);
                  fail_count++;
               end
               if (rsp_mon.link_total !== exp_r.link_total) begin
                  $error("link_total: expected %0d got %0d", exp_r.link_total,
                         rsp_mon.link_total);
                  fail_count++;
               end
               if (rsp_mon.hit_total !== exp_r.hit_total) begin
                  $error("hit_total: expected %0d got %0d", exp_r.hit_total,
                         rsp_mon.hit_total);
                  fail_count++;
               end
               if (rsp_mon.cal_mean !== exp_r.cal_mean) begin
                  $error("cal_mean: expected %0d got %0d", exp_r.cal_mean, rsp_mon.cal_mean);
                  fail_count++;
               end
               if (rsp_mon.link_mean !== exp_r.link_mean) begin
                  $error("link_mean: expected %0d got %0d", exp_r.link_mean,
                         rsp_mon.link_mean);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) expected_responses.push_back(apply_request());
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_AMP_MIN:   amp_lo = csr_mon.data;
               REG_AMP_MAX:   amp_hi = csr_mon.data;
               REG_CAL_MIN:   cal_lo = csr_mon.data[9:0];
               REG_CAL_MAX:   cal_hi = csr_mon.data[9:0];
               REG_RATIO_MIN: ratio_lo = csr_mon.data[5:0];
               REG_RATIO_MAX: ratio_hi = csr_mon.data[5:0];
               default: ;
            endcase
         end
      end
   end
endmodule

// ----- tb/sv/tb.sv -----
// Testbench top: drives pixel requests and cut register writes, reports the verdict.
module tb;
   import phca_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   fail_count;
   int   pending_count;
   int   request_count = 0;
   int   phase_count = 0;

   localparam int CYCLE_LIMIT = 1000000;

   phca_req_if req_ch();
   phca_rsp_if rsp_ch();
   phca_csr_if csr_ch();

   pixel_hit_cut_accumulator dut (.clock(clock), .reset(reset), .req_ch(req_ch),
                                  .rsp_ch(rsp_ch), .csr_ch(csr_ch));

   phca_checker checker_inst (.clock(clock), .reset(reset), .req_mon(req_ch),
                              .rsp_mon(rsp_ch), .csr_mon(csr_ch),
                              .fail_count(fail_count), .pending_count(pending_count));

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // randomize the response stall at every falling edge
   int stall_left = 0;
   logic calm_phase = 1'b0;
   always @(negedge clock) begin
      if (reset || calm_phase) rsp_ch.ready <= 1'b1;
      else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         stall_left <= gap_length();
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic send_request(logic op, logic [3:0] row, logic [3:0] col, logic [9:0] cal,
                               logic [8:0] tot, logic [4:0] link, logic [15:0] amp);
      int gap;
      gap = calm_phase ? 0 : gap_length();
      repeat (gap + 1) @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.pixel_row <= row;
      req_ch.pixel_col <= col;
      req_ch.cal_value <= cal;
      req_ch.tot_value <= tot;
      req_ch.link_id <= link;
      req_ch.amp_ch2 <= amp;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      request_count++;
   endtask

   task automatic write_reg(csr_idx_type idx, logic [15:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_count != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   // a random hit; if wellformed it passes the default cuts: cal 171..189, tot gives a ratio of about 2.3 to 9.7
   task automatic random_hit(logic [3:0] row, logic [3:0] col, logic wellformed);
      logic [9:0] cal;
      logic [8:0] tot;
      logic [15:0] amp;
      if (wellformed) begin
         cal = 10'($urandom_range(171, 189));
         tot = 9'($urandom_range(70, 270));
         amp = 16'($urandom_range(6401, 19199));
      end else begin
         cal = 10'($urandom);
         tot = 9'($urandom);
         amp = 16'($urandom);
      end
      send_request(1'b0, row, col, cal, tot, 5'($urandom), amp);
   endtask

   task automatic random_phase(int count, logic wide);
      logic [3:0] row, col;
      for (int i = 0; i < count; i++) begin
         row = wide ? 4'($urandom) : 4'($urandom_range(0, 3));
         col = wide ? 4'($urandom) : 4'($urandom_range(0, 3));
         if ($urandom_range(0, 7) == 0)
            send_request(1'b1, row, col, 10'($urandom), 9'($urandom), 5'($urandom),
                         16'($urandom));
         else random_hit(row, col, $urandom_range(0, 4) != 0);
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.opcode = 1'b0;
      req_ch.pixel_row = '0;
      req_ch.pixel_col = '0;
      req_ch.cal_value = '0;
      req_ch.tot_value = '0;
      req_ch.link_id = '0;
      req_ch.amp_ch2 = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_AMP_MIN;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: empty pixel read, passing hits, zero cal, field extremes
      send_request(1'b1, 4'd0, 4'd0, '0, '0, '0, '0);
      send_request(1'b0, 4'd0, 4'd0, 10'd180, 9'd200, 5'd31, 16'sd10000);
      send_request(1'b0, 4'd0, 4'd0, 10'd171, 9'd511, 5'd0, 16'sd6401);
      send_request(1'b0, 4'd15, 4'd15, 10'd189, 9'd150, 5'd17, 16'sd19199);
      send_request(1'b0, 4'd1, 4'd1, 10'd0, 9'd511, 5'd1, 16'sd10000);
      send_request(1'b0, 4'd1, 4'd1, 10'd1023, 9'd0, 5'd31, 16'h8000);
      send_request(1'b0, 4'd1, 4'd1, 10'd180, 9'd200, 5'd3, 16'h7fff);
      send_request(1'b0, 4'd1, 4'd1, 10'd170, 9'd200, 5'd3, 16'sd6400);
      send_request(1'b0, 4'd1, 4'd1, 10'd190, 9'd200, 5'd3, 16'sd19200);
      send_request(1'b0, 4'd2, 4'd2, 10'd180, 9'd1, 5'd3, 16'sd10000);
      send_request(1'b1, 4'd0, 4'd0, 10'h3ff, 9'h1ff, 5'h1f, 16'hffff);
      send_request(1'b1, 4'd15, 4'd15, '0, '0, '0, '0);
      drain();

      // wide-open cuts, then inverted windows, then the default windows, then randomized windows
      write_reg(REG_AMP_MIN, 16'h8000);
      write_reg(REG_AMP_MAX, 16'h7fff);
      write_reg(REG_CAL_MIN, 16'd0);
      write_reg(REG_CAL_MAX, 16'h3ff);
      write_reg(REG_RATIO_MIN, 16'd0);
      write_reg(REG_RATIO_MAX, 16'h3f);
      send_request(1'b0, 4'd3, 4'd3, 10'd1, 9'd511, 5'd31, 16'h8001);
      random_phase(200, 1'b1);
      drain();
      write_reg(REG_AMP_MIN, 16'h7fff);
      write_reg(REG_AMP_MAX, 16'h8000);
      write_reg(REG_CAL_MIN, 16'h3ff);
      write_reg(REG_CAL_MAX, 16'd0);
      write_reg(REG_RATIO_MIN, 16'h3f);
      write_reg(REG_RATIO_MAX, 16'd0);
      random_phase(100, 1'b1);
      drain();
      write_reg(3'd7, 16'hffff);
      write_reg(REG_AMP_MIN, 16'sd6400);
      write_reg(REG_AMP_MAX, 16'sd19200);
      write_reg(REG_CAL_MIN, 16'd170);
      write_reg(REG_CAL_MAX, 16'd190);
      write_reg(REG_RATIO_MIN, 16'd2);
      write_reg(REG_RATIO_MAX, 16'd10);
      random_phase(600, 1'b0);
      calm_phase = 1'b1;
      random_phase(150, 1'b0);
      calm_phase = 1'b0;
      drain();
      for (int p = 0; p < 4; p++) begin
         write_reg(REG_AMP_MIN, 16'($urandom_range(0, 8000)));
         write_reg(REG_AMP_MAX, 16'($urandom_range(12000, 32767)));
         write_reg(REG_CAL_MIN, 16'($urandom_range(0, 180)));
         write_reg(REG_CAL_MAX, 16'($urandom_range(180, 1023)));
         write_reg(REG_RATIO_MIN, 16'($urandom_range(0, 4)));
         write_reg(REG_RATIO_MAX, 16'($urandom_range(5, 63)));
         random_phase(220, 1'($urandom_range(0, 1)));
         drain();
         phase_count++;
      end

      $display("%0d requests over %0d cut settings, with stalls on both channels",
               request_count, phase_count + 4);
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
